// File: rtl/lsra_pkg.sv
`timescale 1ns / 1ps

package lsra_pkg;

    localparam int ID_W      = 16;
    localparam int POS_W     = 20;
    localparam int PREG_W    = 6;
    localparam int NUM_PREGS = 64;
    localparam int SLOT_W    = 12;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 2;

    localparam logic [SLOT_W-1:0] SLOT_MAX = {SLOT_W{1'b1}};

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ALLOCATABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CALLEE      = 2'd1;

    typedef struct packed {
        logic [ID_W-1:0]  value_id;
        logic [POS_W-1:0] interval_start;
        logic [POS_W-1:0] interval_end;
        logic             crosses_call;
        logic             new_pass;
        logic             new_function;
    } lsra_in_t;

    typedef struct packed {
        logic [ID_W-1:0]   result_id;
        logic [PREG_W-1:0] phys_reg;
        logic              spilled;
        logic [SLOT_W-1:0] slot_index;
        logic              last_of_run;
    } lsra_out_t;

    // One active-table entry
    typedef struct packed {
        logic [POS_W-1:0]  pos_end;
        logic [ID_W-1:0]   owner;
        logic [PREG_W-1:0] preg;
    } lsra_entry_t;

    // Current eviction candidate
    typedef struct packed {
        logic              found;
        logic [POS_W-1:0]  pos_end;
        logic [ID_W-1:0]   owner;
        logic [PREG_W-1:0] preg;
    } lsra_victim_t;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DECIDE = 4'b0100,
        ST_PAIR   = 4'b1000
    } lsra_state_t;

endpackage

// File: rtl/lsra_table.sv
`timescale 1ns / 1ps

module lsra_table
    import lsra_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int IDXW  = 5
)
(
    input  logic            clk,
    input  logic            wr_en,
    input  logic [IDXW-1:0] wr_addr,
    input  lsra_entry_t     wr_entry,
    input  logic            rd_en,
    input  logic [IDXW-1:0] rd_addr,
    output lsra_entry_t     rd_entry
);

    lsra_entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_entry <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/lsra_scan.sv
`timescale 1ns / 1ps

module lsra_scan
    import lsra_pkg::*;
#(
    parameter int IDXW = 5
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 step,
    input  logic                 entry_valid,
    input  lsra_entry_t          entry,
    input  logic [IDXW-1:0]      entry_idx,
    input  logic [POS_W-1:0]     start_pos,
    input  logic                 crosses_call,
    input  logic [NUM_PREGS-1:0] callee_mask,
    output logic                 expire,
    output lsra_victim_t         victim,
    output logic [IDXW-1:0]      victim_idx
);

    logic              victim_found_reg;
    logic [POS_W-1:0]  victim_end_reg;
    logic [ID_W-1:0]   victim_owner_reg;
    logic [PREG_W-1:0] victim_preg_reg;
    logic [IDXW-1:0]   victim_idx_reg;
    logic              candidate;
    logic              better;

    // Entry ends at or before the new start: retire it
    assign expire = step && entry_valid && (entry.pos_end <= start_pos);

    // Survivors qualify for eviction; call-crossing items need a callee-saved register
    assign candidate = step && entry_valid && !(entry.pos_end <= start_pos)
                       && (!crosses_call || callee_mask[entry.preg]);

    // Farthest end wins, lower owner id breaks a tie, earlier position on full tie
    assign better = !victim_found_reg
                    || (entry.pos_end > victim_end_reg)
                    || ((entry.pos_end == victim_end_reg)
                        && (entry.owner < victim_owner_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            victim_found_reg <= 1'b0;
        end
        else if (start)
        begin
            victim_found_reg <= 1'b0;
        end
        else if (candidate && better)
        begin
            victim_found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (candidate && better)
        begin
            victim_end_reg   <= entry.pos_end;
            victim_owner_reg <= entry.owner;
            victim_preg_reg  <= entry.preg;
            victim_idx_reg   <= entry_idx;
        end
    end

    assign victim     = {victim_found_reg, victim_end_reg, victim_owner_reg, victim_preg_reg};
    assign victim_idx = victim_idx_reg;

endmodule

// File: rtl/linear_scan_register_assigner.sv
`timescale 1ns / 1ps

// Linear-scan register assigner.
// Input channel (in_valid / in_ready / in_data): one live interval per
// transaction, sorted by start. in_ready is high only while the block is idle.
// Output channel (out_valid / out_ready / out_data): one or two decisions per
// interval; last_of_run marks the final one. An eviction gives the spill of
// the evicted value first, then the assignment of the new interval.
// Configuration: cfg_we writes cfg_wdata into the register at cfg_index
// (0 = allocatable mask, 1 = callee-saved mask); write only while idle.
// Timing: after acceptance the sequencer sweeps the active table one entry per
// cycle through a single compare unit, with the table read registered, then
// decides once the result register is free. The next interval can be
// accepted the cycle after the last result is loaded.
// Reset clears the active table valid bits, free mask, slot counter and both
// masks. A stalled receiver holds the result register; the decision step
// waits until that register is free, so nothing is dropped.
module linear_scan_register_assigner
    import lsra_pkg::*;
#(
    parameter int ACTIVE_DEPTH = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  lsra_in_t             in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output lsra_out_t            out_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    localparam int IDXW = (ACTIVE_DEPTH > 1) ? $clog2(ACTIVE_DEPTH) : 1;
    localparam int CNTW = $clog2(ACTIVE_DEPTH + 1);
    localparam logic [CNTW-1:0] LAST_CNT = CNTW'(ACTIVE_DEPTH);

    // Lowest set bit of the free mask
    function automatic logic [PREG_W-1:0] lowest_preg(input logic [NUM_PREGS-1:0] mask);
        logic [PREG_W-1:0] r;
        r = '0;
        for (int i = NUM_PREGS - 1; i >= 0; i--)
        begin
            if (mask[i])
            begin
                r = PREG_W'(i);
            end
        end
        return r;
    endfunction

    // Lowest empty table position
    function automatic logic [IDXW-1:0] lowest_hole(input logic [ACTIVE_DEPTH-1:0] valid);
        logic [IDXW-1:0] h;
        h = '0;
        for (int i = ACTIVE_DEPTH - 1; i >= 0; i--)
        begin
            if (!valid[i])
            begin
                h = IDXW'(i);
            end
        end
        return h;
    endfunction

    lsra_state_t             state_reg, state_next;
    logic [CNTW-1:0]         cnt_reg, cnt_next;
    lsra_in_t                item_reg, item_next;
    logic [NUM_PREGS-1:0]    alloc_mask_reg;
    logic [NUM_PREGS-1:0]    callee_mask_reg;
    logic [NUM_PREGS-1:0]    free_reg, free_next;
    logic [ACTIVE_DEPTH-1:0] valid_reg, valid_next;
    logic [SLOT_W-1:0]       slot_reg, slot_next;
    logic                    out_valid_reg, out_valid_next;
    lsra_out_t               out_data_reg, out_data_next;

    logic            accept;
    logic            proc;
    logic [CNTW-1:0] cnt_m1;
    logic [IDXW-1:0] pidx;
    logic            out_free;

    logic            tbl_wr_en;
    logic [IDXW-1:0] tbl_wr_addr;
    lsra_entry_t     tbl_wr_entry;
    logic            tbl_rd_en;
    lsra_entry_t     tbl_rd_entry;

    logic            expire;
    lsra_victim_t    victim;
    logic [IDXW-1:0] victim_idx;

    logic [NUM_PREGS-1:0] avail;
    logic [PREG_W-1:0]    pick_preg;
    logic [IDXW-1:0]      hole;
    logic                 can_assign;
    logic                 can_evict;
    logic [SLOT_W-1:0]    slot_bumped;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || out_ready;

    // Read address leads the processed entry by one table position
    assign tbl_rd_en = (state_reg == ST_SCAN) && (cnt_reg != LAST_CNT);
    assign proc      = (state_reg == ST_SCAN) && (cnt_reg != '0);
    assign cnt_m1    = cnt_reg - CNTW'(1);
    assign pidx      = cnt_m1[IDXW-1:0];

    lsra_table #(
        .DEPTH (ACTIVE_DEPTH),
        .IDXW  (IDXW)
    ) u_table (
        .clk      (clk),
        .wr_en    (tbl_wr_en),
        .wr_addr  (tbl_wr_addr),
        .wr_entry (tbl_wr_entry),
        .rd_en    (tbl_rd_en),
        .rd_addr  (cnt_reg[IDXW-1:0]),
        .rd_entry (tbl_rd_entry)
    );

    lsra_scan #(
        .IDXW (IDXW)
    ) u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (accept),
        .step         (proc),
        .entry_valid  (valid_reg[pidx]),
        .entry        (tbl_rd_entry),
        .entry_idx    (pidx),
        .start_pos    (item_reg.interval_start),
        .crosses_call (item_reg.crosses_call),
        .callee_mask  (callee_mask_reg),
        .expire       (expire),
        .victim       (victim),
        .victim_idx   (victim_idx)
    );

    // Decision terms, settled once the sweep is done
    assign avail       = free_reg & (item_reg.crosses_call ? callee_mask_reg : '1);
    assign pick_preg   = lowest_preg(avail);
    assign hole        = lowest_hole(valid_reg);
    assign can_assign  = (|avail) && !(&valid_reg);
    assign can_evict   = victim.found && (victim.pos_end > item_reg.interval_end);
    assign slot_bumped = (slot_reg == SLOT_MAX) ? slot_reg : slot_reg + SLOT_W'(1);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        item_next      = item_reg;
        free_next      = free_reg;
        valid_next     = valid_reg;
        slot_next      = slot_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        tbl_wr_en      = 1'b0;
        tbl_wr_addr    = hole;
        tbl_wr_entry.pos_end = item_reg.interval_end;
        tbl_wr_entry.owner   = item_reg.value_id;
        tbl_wr_entry.preg    = pick_preg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    item_next  = in_data;
                    cnt_next   = '0;
                    state_next = ST_SCAN;
                    if (in_data.new_function)
                    begin
                        slot_next = '0;
                    end
                    if (in_data.new_function || in_data.new_pass)
                    begin
                        valid_next = '0;
                        free_next  = alloc_mask_reg;
                    end
                end
            end

            ST_SCAN:
            begin
                // Retire the entry under the compare unit
                if (expire)
                begin
                    free_next[tbl_rd_entry.preg] = 1'b1;
                    valid_next[pidx]             = 1'b0;
                end
                cnt_next = cnt_reg + CNTW'(1);
                if (cnt_reg == LAST_CNT)
                begin
                    state_next = ST_DECIDE;
                end
            end

            ST_DECIDE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (can_assign)
                    begin
                        free_next[pick_preg] = 1'b0;
                        valid_next[hole]     = 1'b1;
                        tbl_wr_en            = 1'b1;
                        out_data_next.result_id   = item_reg.value_id;
                        out_data_next.phys_reg    = pick_preg;
                        out_data_next.spilled     = 1'b0;
                        out_data_next.slot_index  = '0;
                        out_data_next.last_of_run = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else if (can_evict)
                    begin
                        // Hand the victim's register over; its entry now holds the new interval
                        tbl_wr_en         = 1'b1;
                        tbl_wr_addr       = victim_idx;
                        tbl_wr_entry.preg = victim.preg;
                        slot_next         = slot_bumped;
                        out_data_next.result_id   = victim.owner;
                        out_data_next.phys_reg    = '0;
                        out_data_next.spilled     = 1'b1;
                        out_data_next.slot_index  = slot_reg;
                        out_data_next.last_of_run = 1'b0;
                        state_next = ST_PAIR;
                    end
                    else
                    begin
                        slot_next = slot_bumped;
                        out_data_next.result_id   = item_reg.value_id;
                        out_data_next.phys_reg    = '0;
                        out_data_next.spilled     = 1'b1;
                        out_data_next.slot_index  = slot_reg;
                        out_data_next.last_of_run = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_PAIR:
            begin
                // Follow the spill with the new interval's assignment
                if (out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next.result_id   = item_reg.value_id;
                    out_data_next.phys_reg    = victim.preg;
                    out_data_next.spilled     = 1'b0;
                    out_data_next.slot_index  = '0;
                    out_data_next.last_of_run = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cnt_reg         <= '0;
            free_reg        <= '0;
            valid_reg       <= '0;
            slot_reg        <= '0;
            out_valid_reg   <= 1'b0;
            alloc_mask_reg  <= '0;
            callee_mask_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            free_reg      <= free_next;
            valid_reg     <= valid_next;
            slot_reg      <= slot_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we && (cfg_index == REG_ALLOCATABLE))
            begin
                alloc_mask_reg <= cfg_wdata;
            end
            if (cfg_we && (cfg_index == REG_CALLEE))
            begin
                callee_mask_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers: no reset needed
    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: rtl/lsra_checker.sv
`timescale 1ns / 1ps

module lsra_checker
    import lsra_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input lsra_in_t  in_data,
    input logic      out_valid,
    input logic      out_ready,
    input lsra_out_t out_data
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // Busy right after taking an interval
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken again without processing");

    // No new interval while an eviction pair is half delivered
    a_pair_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.last_of_run |-> !in_ready)
        else $error("input ready in the middle of an eviction pair");

    // An evicted spill is followed at once by the new interval's assignment
    a_pair_follow: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_data.last_of_run
        |=> out_valid && out_data.last_of_run && !out_data.spilled)
        else $error("eviction spill not followed by assignment");

    // Spill carries no register, assignment carries no slot
    a_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.spilled ? (out_data.phys_reg == '0)
                                        : (out_data.slot_index == '0)))
        else $error("unused result field not zero");

endmodule

bind linear_scan_register_assigner lsra_checker u_lsra_checker (.*);

// File: test/lsra_checker.sv
`timescale 1ns / 1ps

module lsra_scoreboard
    import lsra_pkg::*;
#(
    parameter int ACTIVE_DEPTH = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  lsra_in_t             in_data,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  lsra_out_t            out_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    output int                   errors,
    output int                   pending
);

    // Shadow copy of the allocator state
    logic [CFG_W-1:0]  alloc_mask;
    logic [CFG_W-1:0]  callee_mask;
    logic [CFG_W-1:0]  free_regs;
    logic [SLOT_W-1:0] next_spill;
    logic              held      [ACTIVE_DEPTH];
    logic [POS_W-1:0]  held_end  [ACTIVE_DEPTH];
    logic [ID_W-1:0]   held_owner[ACTIVE_DEPTH];
    logic [PREG_W-1:0] held_reg  [ACTIVE_DEPTH];

    lsra_out_t pending_decisions[$];

    function automatic lsra_out_t decision(input logic [ID_W-1:0] id,
                                           input logic [PREG_W-1:0] preg,
                                           input logic spill,
                                           input logic [SLOT_W-1:0] slot,
                                           input logic last);
        lsra_out_t d;
        d.result_id   = id;
        d.phys_reg    = preg;
        d.spilled     = spill;
        d.slot_index  = slot;
        d.last_of_run = last;
        return d;
    endfunction

    // Hand out the next stack slot; the counter sticks at its top value
    function automatic logic [SLOT_W-1:0] claim_slot();
        logic [SLOT_W-1:0] s;
        s = next_spill;
        if (next_spill != SLOT_MAX)
            next_spill = next_spill + SLOT_W'(1);
        return s;
    endfunction

    // Queue a predicted decision behind the ones already waiting
    task automatic post_decision(input lsra_out_t d);
        pending_decisions.insert(pending_decisions.size(), d);
    endtask

    task automatic decide_interval(input lsra_in_t iv);
        logic [CFG_W-1:0] avail;
        int               hole;
        int               victim;
        int               r;
        hole   = -1;
        victim = -1;
        if (iv.new_function)
            next_spill = '0;
        if (iv.new_pass || iv.new_function)
        begin
            for (int i = 0; i < ACTIVE_DEPTH; i++)
                held[i] = 1'b0;
            free_regs = alloc_mask;
        end
        // Retire everything that ends at or before the new start
        for (int i = 0; i < ACTIVE_DEPTH; i++)
        begin
            if (held[i] && held_end[i] <= iv.interval_start)
            begin
                free_regs[held_reg[i]] = 1'b1;
                held[i] = 1'b0;
            end
        end
        for (int i = 0; i < ACTIVE_DEPTH; i++)
        begin
            if (!held[i] && hole < 0)
                hole = i;
        end
        avail = free_regs & (iv.crosses_call ? callee_mask : {CFG_W{1'b1}});
        if (avail != '0 && hole >= 0)
        begin
            r = 0;
            while (!avail[r])
                r++;
            free_regs[r]     = 1'b0;
            held[hole]       = 1'b1;
            held_end[hole]   = iv.interval_end;
            held_owner[hole] = iv.value_id;
            held_reg[hole]   = PREG_W'(r);
            post_decision(decision(iv.value_id, PREG_W'(r), 1'b0, '0, 1'b1));
            return;
        end
        // Farthest end wins, lowest owner on a tie, first position on equal owners
        for (int i = 0; i < ACTIVE_DEPTH; i++)
        begin
            if (held[i] && !(iv.crosses_call && !callee_mask[held_reg[i]]))
            begin
                if (victim < 0 || held_end[i] > held_end[victim] ||
                    (held_end[i] == held_end[victim] &&
                     held_owner[i] < held_owner[victim]))
                    victim = i;
            end
        end
        if (victim >= 0 && held_end[victim] > iv.interval_end)
        begin
            post_decision(decision(held_owner[victim], '0, 1'b1, claim_slot(), 1'b0));
            post_decision(decision(iv.value_id, held_reg[victim], 1'b0, '0, 1'b1));
            held_end[victim]   = iv.interval_end;
            held_owner[victim] = iv.value_id;
            return;
        end
        post_decision(decision(iv.value_id, '0, 1'b1, claim_slot(), 1'b1));
    endtask

    task automatic flag_bad(input lsra_out_t want, input lsra_out_t got, input bit had_want);
        errors++;
        if (errors <= 10)
        begin
            if (!had_want)
                $display("[%0t] unexpected result: id=%0d reg=%0d spill=%0b slot=%0d last=%0b",
                         $time, got.result_id, got.phys_reg, got.spilled,
                         got.slot_index, got.last_of_run);
            else
                $display({"[%0t] bad result: expected id=%0d reg=%0d spill=%0b slot=%0d ",
                          "last=%0b, got id=%0d reg=%0d spill=%0b slot=%0d last=%0b"},
                         $time, want.result_id, want.phys_reg, want.spilled,
                         want.slot_index, want.last_of_run, got.result_id, got.phys_reg,
                         got.spilled, got.slot_index, got.last_of_run);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        lsra_out_t want;
        if (!rst_n)
        begin
            alloc_mask  = '0;
            callee_mask = '0;
            free_regs   = '0;
            next_spill  = '0;
            for (int i = 0; i < ACTIVE_DEPTH; i++)
            begin
                held[i]       = 1'b0;
                held_end[i]   = '0;
                held_owner[i] = '0;
                held_reg[i]   = '0;
            end
            pending_decisions.delete();
            errors = 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ALLOCATABLE: alloc_mask  = cfg_wdata;
                    REG_CALLEE:      callee_mask = cfg_wdata;
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (pending_decisions.size() == 0)
                    flag_bad(out_data, out_data, 1'b0);
                else
                begin
                    want = pending_decisions.pop_front();
                    if (out_data.result_id   !== want.result_id  ||
                        out_data.phys_reg    !== want.phys_reg   ||
                        out_data.spilled     !== want.spilled    ||
                        out_data.slot_index  !== want.slot_index ||
                        out_data.last_of_run !== want.last_of_run)
                        flag_bad(want, out_data, 1'b1);
                end
            end
            if (in_valid && in_ready)
                decide_interval(in_data);
            pending <= pending_decisions.size();
        end
    end

endmodule

// File: test/tb_linear_scan_register_assigner.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the register assigner. The checker module beside
// the block shadows the allocator and compares every decision; this module
// only drives intervals, configuration and back-pressure.
module tb_linear_scan_register_assigner;

    import lsra_pkg::*;

    localparam int ACTIVE_DEPTH    = 32;
    localparam int POS_MAX         = (1 << POS_W) - 1;
    localparam int RANDOM_ITEMS    = 1050;
    // A short stretch where every interval spills
    localparam int SATURATE_ITEMS  = 60;
    localparam int CYCLE_LIMIT     = 3_000_000;

    // Mask settings that the random phases rotate through
    typedef enum int {
        CFG_FULL,
        CFG_RANDOM,
        CFG_SPARSE,
        CFG_NO_CALLEE,
        CFG_NONE,
        CFG_EDGE_REGS,
        CFG_MODE_COUNT
    } cfg_mode_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    lsra_in_t             in_data;
    logic                 out_valid;
    logic                 out_ready;
    lsra_out_t            out_data;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;

    int errors;
    int pending;
    int cycle_count = 0;
    int accepted    = 0;
    bit calm        = 1'b0;

    linear_scan_register_assigner #(
        .ACTIVE_DEPTH(ACTIVE_DEPTH)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    lsra_scoreboard #(
        .ACTIVE_DEPTH(ACTIVE_DEPTH)
    ) checker_i (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .errors   (errors),
        .pending  (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop in case the block hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("linear_scan_register_assigner: mismatch");
            $finish;
        end
    end

    // Receiver back-pressure: drop ready on roughly one cycle in seven,
    // except during the calm stretch where the sink always takes results.
    always @(negedge clk)
    begin
        if (rst_n === 1'b1)
            out_ready <= calm || ($urandom_range(0, 99) >= 14);
    end

    function automatic lsra_in_t interval(input logic [ID_W-1:0]  id,
                                          input logic [POS_W-1:0] st,
                                          input logic [POS_W-1:0] en,
                                          input logic             cc,
                                          input logic             np,
                                          input logic             nf);
        lsra_in_t it;
        it.value_id       = id;
        it.interval_start = st;
        it.interval_end   = en;
        it.crosses_call   = cc;
        it.new_pass       = np;
        it.new_function   = nf;
        return it;
    endfunction

    // Present one interval at a falling edge and hold it until the block takes
    // the transaction. A random gap before valid lands on whatever phase the
    // block happens to be in.
    task automatic send_interval(input lsra_in_t it);
        @(negedge clk);
        if (!calm && $urandom_range(0, 99) < 14)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 45)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        accepted++;
    endtask

    // Drop valid and hold off until every predicted decision has come out
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic load_masks(input cfg_mode_t mode);
        logic [CFG_W-1:0] alloc;
        logic [CFG_W-1:0] callee;
        case (mode)
            CFG_FULL:
            begin
                alloc  = '1;
                callee = '1;
            end
            CFG_RANDOM:
            begin
                alloc  = {$urandom(), $urandom()};
                callee = {$urandom(), $urandom()};
            end
            CFG_SPARSE:
            begin
                // A handful of registers: evictions and spills happen a lot
                alloc  = {$urandom(), $urandom()} & {$urandom(), $urandom()} &
                         {$urandom(), $urandom()};
                callee = alloc & {$urandom(), $urandom()};
            end
            CFG_NO_CALLEE:
            begin
                alloc  = '1;
                callee = '0;
            end
            CFG_NONE:
            begin
                alloc  = '0;
                callee = '1;
            end
            default:
            begin
                alloc  = 64'h8000_0000_0000_0001;
                callee = 64'h8000_0000_0000_0000;
            end
        endcase
        write_reg(REG_ALLOCATABLE, alloc);
        write_reg(REG_CALLEE, callee);
    endtask

    // One pass of intervals sorted by start, with random lengths and a few
    // empty or reversed ones. About one item in twenty is pure noise.
    task automatic run_pass(input int count, input bit fresh_function);
        int          cursor;
        int          span;
        int          pick;
        logic [63:0] noise;
        lsra_in_t    it;
        cursor = $urandom_range(0, POS_MAX);
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 99) < 5)
            begin
                noise = {$urandom(), $urandom()};
                it    = noise[$bits(lsra_in_t)-1:0];
            end
            else
            begin
                cursor = cursor + int'($urandom_range(0, 3));
                if (cursor > POS_MAX)
                    cursor = POS_MAX;
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    span = cursor + int'($urandom_range(0, 60));
                else if (pick < 92)
                    span = cursor + int'($urandom_range(60, 5000));
                else
                    span = cursor - int'($urandom_range(0, 50));
                if (span > POS_MAX)
                    span = POS_MAX;
                if (span < 0)
                    span = 0;
                // Half the ids come from a tiny pool to force owner ties
                it = interval($urandom_range(0, 1) ? ID_W'($urandom()) :
                                                     ID_W'($urandom_range(0, 7)),
                              POS_W'(cursor), POS_W'(span),
                              $urandom_range(0, 99) < 30,
                              k == 0, (k == 0) && fresh_function);
            end
            send_interval(it);
            if ($urandom_range(0, 99) < 2)
                wait_drained();
        end
    endtask

    initial
    begin : stimulus
        int          phase;
        int          random_base;
        logic [63:0] noise;
        lsra_in_t    it;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_ready = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_ALLOCATABLE;
        cfg_wdata = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // No pass started yet: free mask is empty, so this one spills
        send_interval(interval(16'hFFFF, 20'h0, 20'hFFFFF, 1'b1, 1'b0, 1'b0));
        wait_drained();

        // Registers 0, 1 and 63 usable; 1 and 63 survive calls
        write_reg(REG_ALLOCATABLE, 64'h8000_0000_0000_0003);
        write_reg(REG_CALLEE, 64'h8000_0000_0000_0002);

        send_interval(interval(16'd0, 20'd0, 20'd100, 1'b1, 1'b0, 1'b1));
        send_interval(interval(16'd5, 20'd1, 20'd50, 1'b0, 1'b0, 1'b0));
        send_interval(interval(16'd7, 20'd2, 20'd200, 1'b0, 1'b0, 1'b0));
        // Full register file: evict the farthest end
        send_interval(interval(16'd9, 20'd3, 20'd60, 1'b0, 1'b0, 1'b0));
        // Call-crossing with nothing worth evicting: spill itself
        send_interval(interval(16'd11, 20'd4, 20'd300, 1'b1, 1'b0, 1'b0));
        send_interval(interval(16'd3, 20'd5, 20'd10, 1'b0, 1'b0, 1'b0));
        // Equal ends: the lowest owner id loses its register
        send_interval(interval(16'd20, 20'd10, 20'd500, 1'b0, 1'b1, 1'b0));
        send_interval(interval(16'd10, 20'd10, 20'd500, 1'b0, 1'b0, 1'b0));
        send_interval(interval(16'd30, 20'd10, 20'd500, 1'b0, 1'b0, 1'b0));
        send_interval(interval(16'd40, 20'd11, 20'd100, 1'b0, 1'b0, 1'b0));
        // Equal ends and equal owners: the first table position loses
        send_interval(interval(16'd8, 20'd20, 20'd700, 1'b0, 1'b1, 1'b0));
        send_interval(interval(16'd8, 20'd20, 20'd700, 1'b0, 1'b0, 1'b0));
        send_interval(interval(16'd8, 20'd20, 20'd700, 1'b0, 1'b0, 1'b0));
        send_interval(interval(16'd9, 20'd21, 20'd30, 1'b0, 1'b0, 1'b0));
        // Reversed and empty intervals retire on the next input
        send_interval(interval(16'd100, 20'd40, 20'd25, 1'b0, 1'b1, 1'b0));
        send_interval(interval(16'd101, 20'd41, 20'd41, 1'b0, 1'b0, 1'b0));
        send_interval(interval(16'd102, 20'd42, 20'd90, 1'b0, 1'b0, 1'b0));
        // Position and id extremes
        send_interval(interval(16'hFFFF, 20'hFFFFF, 20'hFFFFF, 1'b1, 1'b0, 1'b0));
        send_interval(interval(16'h0, 20'hFFFFF, 20'h0, 1'b0, 1'b0, 1'b0));

        // Random phases: drain, reload both masks, then run a few passes
        random_base = accepted;
        phase       = 0;
        while (accepted - random_base < RANDOM_ITEMS)
        begin
            wait_drained();
            load_masks(cfg_mode_t'(phase % CFG_MODE_COUNT));
            // One whole phase runs with neither side idling
            calm = (phase == 2);
            repeat ($urandom_range(2, 5))
                run_pass($urandom_range(4, 60), $urandom_range(0, 3) == 0);
            phase++;
        end
        calm = 1'b0;

        // Nothing allocatable: every interval spills and takes the next slot
        wait_drained();
        load_masks(CFG_NONE);
        send_interval(interval(16'd1, 20'd0, 20'd10, 1'b0, 1'b1, 1'b1));
        for (int k = 0; k < SATURATE_ITEMS; k++)
        begin
            noise           = {$urandom(), $urandom()};
            it              = noise[$bits(lsra_in_t)-1:0];
            it.new_pass     = 1'b0;
            it.new_function = 1'b0;
            send_interval(it);
        end
        // Restart the function: slots count from zero again
        send_interval(interval(16'd2, 20'd0, 20'd10, 1'b0, 1'b1, 1'b1));

        wait_drained();
        repeat (ACTIVE_DEPTH + 10) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("linear_scan_register_assigner: match");
        else
            $display("linear_scan_register_assigner: mismatch");
        $finish;
    end

endmodule
